// File: sv/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every rising clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/sdc_pkg.sv
`timescale 1ns / 1ps

package sdc_pkg;

  localparam int unsigned DataW  = 64;
  localparam int unsigned CheckW = 8;
  localparam int unsigned SynW   = 7;

  localparam logic [SynW-1:0]   SynMask    = 7'h7F;
  localparam logic [CheckW-1:0] OverallBit = 8'h80;

  // Highest code position that exists in a 72-bit codeword.
  localparam logic [SynW-1:0] MaxPos = 7'd71;

  typedef enum logic {
    OpEncode = 1'b0,
    OpDecode = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    StOk     = 2'd0,
    StCorr   = 2'd1,
    StUncorr = 2'd2
  } status_e;

  // Recomputed check bits and the parity of the data word.
  typedef struct packed {
    logic [SynW-1:0] check;
    logic            parity;
  } chk_t;

  // Code position of data bit d: count up, skipping powers of two.
  function automatic logic [SynW-1:0] data_pos(int unsigned d);
    int unsigned pos;
    pos = d + 1;
    for (int unsigned k = 0; k < SynW; k++) begin
      if (pos >= (1 << k)) begin
        pos++;
      end
    end
    return pos[SynW-1:0];
  endfunction

  // Data bits that feed check bit i.
  function automatic logic [DataW-1:0] check_mask(int unsigned i);
    logic [DataW-1:0] mask;
    logic [SynW-1:0]  pos;
    mask = '0;
    for (int unsigned d = 0; d < DataW; d++) begin
      pos = data_pos(d);
      mask[d] = pos[i];
    end
    return mask;
  endfunction

endpackage

// File: sv/sdc_checkgen.sv
`timescale 1ns / 1ps

module sdc_checkgen (
  input  logic [sdc_pkg::DataW-1:0] data_i,
  output sdc_pkg::chk_t             chk_o
);
  import sdc_pkg::*;

  for (genvar i = 0; i < SynW; i++) begin : g_check
    assign chk_o.check[i] = ^(data_i & check_mask(i));
  end

  assign chk_o.parity = ^data_i;

endmodule

// File: sv/secded_72_64_codec.sv
`timescale 1ns / 1ps
// Channel   Dir  tdata (low bit up)                tuser
// s_axis    in   data_in[63:0], check_in[71:64]    opcode
// m_axis    out  data_out[63:0], check_out[71:64]  status[1:0]
//
// Four register stages: capture, check-bit parity trees, syndrome and
// encode byte, correction into the output register. One transaction is
// taken every cycle unless a stall on m_axis has filled every stage.
// Each stage holds only while it is full and the stage after it holds, so
// a stall on m_axis loses nothing and the input keeps filling empty stages.
// Reset empties every stage; there is no stored state besides the pipeline.
`include "assert_macros.svh"

module secded_72_64_codec (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // data_in[63:0], check_in[71:64]
  input  logic        s_axis_tuser,   // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // data_out[63:0], check_out[71:64]
  output logic [1:0]  m_axis_tuser    // status[1:0]
);
  import sdc_pkg::*;

  logic [3:0] vld_q, vld_d;
  logic [3:0] rdy;

  // Stage 0: captured transaction.
  op_e               op0_q;
  logic [DataW-1:0]  data0_q;
  logic [CheckW-1:0] chk0_q;

  // Stage 1: parity trees done.
  op_e               op1_q;
  logic [DataW-1:0]  data1_q;
  logic [CheckW-1:0] chk1_q;
  chk_t              cg1_q;
  chk_t              cg0;

  // Stage 2: syndrome and encode byte.
  op_e               op2_q;
  logic [DataW-1:0]  data2_q;
  logic [SynW-1:0]   syn2_q, syn2_d;
  logic              mism2_q, mism2_d;
  logic [CheckW-1:0] enc2_q, enc2_d;

  // Stage 3: output register.
  op_e               op3_q;
  logic [DataW-1:0]  data3_q, data3_d;
  logic [CheckW-1:0] chkout3_q, chkout3_d;
  status_e           status3_q, status3_d;

  logic [DataW-1:0]  fix;

  // Handshake: a stage advances when it is empty or its successor advances.
  always_comb begin
    rdy[3] = !vld_q[3] || m_axis_tready;
    rdy[2] = !vld_q[2] || rdy[3];
    rdy[1] = !vld_q[1] || rdy[2];
    rdy[0] = !vld_q[0] || rdy[1];
    vld_d  = vld_q;
    if (rdy[0]) vld_d[0] = s_axis_tvalid;
    if (rdy[1]) vld_d[1] = vld_q[0];
    if (rdy[2]) vld_d[2] = vld_q[1];
    if (rdy[3]) vld_d[3] = vld_q[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  sdc_checkgen u_checkgen (
    .data_i (data0_q),
    .chk_o  (cg0)
  );

  // Syndrome, parity mismatch and the encoded check byte.
  always_comb begin
    syn2_d  = (cg1_q.check ^ chk1_q[SynW-1:0]) & SynMask;
    mism2_d = cg1_q.parity ^ (^(chk1_q[SynW-1:0] & SynMask)) ^ (|(chk1_q & OverallBit));
    enc2_d  = {cg1_q.parity ^ (^cg1_q.check), cg1_q.check};
  end

  for (genvar d = 0; d < DataW; d++) begin : g_fix
    assign fix[d] = (data_pos(d) == syn2_q);
  end

  // Encode: pass the check byte on. Decode: classify the syndrome and repair a single data-bit error.
  always_comb begin
    data3_d   = data2_q;
    chkout3_d = '0;
    status3_d = StOk;
    unique case (op2_q)
      OpEncode: begin
        chkout3_d = enc2_q;
      end
      OpDecode: begin
        if (!mism2_q) begin
          status3_d = (syn2_q == '0) ? StOk : StUncorr;
        end else if ((syn2_q & (syn2_q - 1'b1)) == '0) begin
          // overall bit or one check bit flipped
          status3_d = StCorr;
        end else if (syn2_q > MaxPos) begin
          status3_d = StUncorr;
        end else begin
          data3_d   = data2_q ^ fix;
          status3_d = StCorr;
        end
      end
      default: begin
        status3_d = StOk;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      op0_q   <= op_e'(s_axis_tuser);
      data0_q <= s_axis_tdata[DataW-1:0];
      chk0_q  <= s_axis_tdata[DataW+CheckW-1:DataW];
    end
    if (rdy[1]) begin
      op1_q   <= op0_q;
      data1_q <= data0_q;
      chk1_q  <= chk0_q;
      cg1_q   <= cg0;
    end
    if (rdy[2]) begin
      op2_q   <= op1_q;
      data2_q <= data1_q;
      syn2_q  <= syn2_d;
      mism2_q <= mism2_d;
      enc2_q  <= enc2_d;
    end
    if (rdy[3]) begin
      op3_q     <= op2_q;
      data3_q   <= data3_d;
      chkout3_q <= chkout3_d;
      status3_q <= status3_d;
    end
  end

  assign s_axis_tready = rdy[0];
  assign m_axis_tvalid = vld_q[3];
  assign m_axis_tdata  = {chkout3_q, data3_q};
  assign m_axis_tuser  = status3_q;

  `ASSERT_CLK(a_enc_status_ok, clk_i, rst_ni, (m_axis_tvalid && op3_q == OpEncode) |-> (m_axis_tuser == StOk), "encode result carries an error status")
  `ASSERT_CLK(a_dec_check_zero, clk_i, rst_ni, (m_axis_tvalid && op3_q == OpDecode) |-> (m_axis_tdata[DataW+CheckW-1:DataW] == '0), "decode result carries a check byte")
  `ASSERT_CLK(a_empty_ready, clk_i, rst_ni, (vld_q == '0) |-> s_axis_tready, "empty pipeline refuses input")
  `ASSERT_ALWAYS(a_reset_no_valid, clk_i, !rst_ni |-> !m_axis_tvalid, "output valid during reset")

endmodule
